### sv/sacf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacf_pkg
// Types and constants shared by the set-associative write-through cache.
// ----------------------------------------------------------------------------
package sacf_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_READ,
    ST_RESULT
  } state_e;

  localparam int unsigned AGE_W   = 4;
  localparam logic [AGE_W-1:0] AGE_MAX = 4'hF;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned QDEPTH  = 2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic             hit;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
  } out_t;

  typedef struct packed {
    op_e         kind;
    logic [15:0] address;
    logic [7:0]  wdata;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic res_valid;
  } status_t;

endpackage

### sv/sacf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacf_front
// Accepts access beats, decodes the operation and queues commands for the
// back end.
// ----------------------------------------------------------------------------
module sacf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sacf_pkg::in_t   req_i,
  output logic            full_o,
  input  logic            cmd_pop_i,
  output logic            cmd_valid_o,
  output sacf_pkg::cmd_t  cmd_o
);

  localparam int unsigned PTR_W = $clog2(sacf_pkg::QDEPTH);
  localparam int unsigned CNT_QW = $clog2(sacf_pkg::QDEPTH + 1);

  sacf_pkg::cmd_t    q_mem [sacf_pkg::QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_QW-1:0] cnt_q;
  logic              do_push, do_pop;
  sacf_pkg::cmd_t    cmd_in;

  always_comb begin
    cmd_in.kind    = sacf_pkg::op_e'(req_i.op);
    cmd_in.address = req_i.address;
    cmd_in.wdata   = req_i.write_data;
  end

  assign full_o      = (cnt_q == CNT_QW'(sacf_pkg::QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_QW'(1);
      end
    end
  end

endmodule

### sv/sacf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacf_back
// Carries out queued accesses: tag lookup, FIFO line fill from the backing
// memory, write-through, flush and the hit and miss counters.
// ----------------------------------------------------------------------------
module sacf_back #(
  parameter int unsigned WAYS       = 8,
  parameter int unsigned SETS       = 32,
  parameter int unsigned LINE_WORDS = 32,
  parameter int unsigned ADDR_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  sacf_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  logic                res_full_i,
  output sacf_pkg::status_t   status_o,
  output sacf_pkg::out_t      res_o
);

  localparam int unsigned OFF_W   = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int unsigned SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TAG_RAW = ADDR_BITS - $clog2(LINE_WORDS * SETS);
  localparam int unsigned TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int unsigned IDX_W   = $clog2(LINE_WORDS + 1);
  localparam int unsigned D_DEPTH = WAYS * SETS * LINE_WORDS;
  localparam int unsigned D_AW    = (D_DEPTH > 1) ? $clog2(D_DEPTH) : 1;
  localparam int unsigned M_DEPTH = 2 ** ADDR_BITS;
  localparam int unsigned AW      = sacf_pkg::AGE_W;
  localparam int unsigned CW      = sacf_pkg::CNT_W;

  sacf_pkg::state_e state_q, state_d;
  sacf_pkg::cmd_t   cmd_q;

  logic [7:0]                  bmem [M_DEPTH];
  logic [7:0]                  dmem [D_DEPTH];
  logic [WAYS-1:0][TAG_W-1:0]  tag_mem [SETS];
  logic [WAYS-1:0][AW-1:0]     age_mem [SETS];
  logic [WAYS-1:0]             valid_q [SETS];

  logic [WAYS-1:0][TAG_W-1:0]  tag_row_q, tag_row_new;
  logic [WAYS-1:0][AW-1:0]     age_row_q, age_row_new;
  logic [7:0]                  bmem_rd_q, dmem_rd_q;
  logic [ADDR_BITS-1:0]        clr_q;
  logic [IDX_W-1:0]            fill_idx_q;
  logic [WAY_W-1:0]            fill_way_q;
  logic [7:0]                  rdata_q;
  logic                        hit_q;
  logic [CW-1:0]               hits_q, misses_q;

  logic [ADDR_BITS-1:0] addr_in, addr_c, base_c;
  logic [SET_W-1:0]     set_in, set_c;
  logic [TAG_W-1:0]     tag_c;
  logic [OFF_W-1:0]     off_c, fill_off;
  logic [WAYS-1:0]      vrow, hit_vec;
  logic                 hit_any;
  logic [WAY_W-1:0]     hit_way, victim;
  logic [AW-1:0]        best_age;
  logic                 found;
  logic [WAYS-1:0][AW-1:0] aged;

  logic                 bm_we;
  logic [ADDR_BITS-1:0] bm_waddr, bm_raddr;
  logic [7:0]           bm_wdata;
  logic                 dm_we;
  logic [D_AW-1:0]      dm_waddr, dm_raddr;
  logic [7:0]           dm_wdata;
  logic                 row_we;
  logic                 do_lookup;

  function automatic logic [D_AW-1:0] d_index(input logic [WAY_W-1:0] way,
                                              input logic [SET_W-1:0] set,
                                              input logic [OFF_W-1:0] off);
    logic [D_AW+WAY_W+SET_W+OFF_W-1:0] lin;
    lin = ((($bits(lin))'(way) * ($bits(lin))'(SETS) + ($bits(lin))'(set))
           * ($bits(lin))'(LINE_WORDS)) + ($bits(lin))'(off);
    return lin[D_AW-1:0];
  endfunction

  assign addr_in = ADDR_BITS'(cmd_i.address);
  assign set_in  = SET_W'((addr_in / LINE_WORDS) % SETS);
  assign addr_c  = ADDR_BITS'(cmd_q.address);
  assign off_c   = OFF_W'(addr_c % LINE_WORDS);
  assign set_c   = SET_W'((addr_c / LINE_WORDS) % SETS);
  assign tag_c   = TAG_W'(addr_c / (LINE_WORDS * SETS));
  assign base_c  = addr_c - ADDR_BITS'(off_c);
  assign vrow    = valid_q[set_c];
  assign fill_off = OFF_W'(fill_idx_q - IDX_W'(1));

  always_comb begin
    hit_vec = '0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = vrow[w] && (tag_row_q[w] == tag_c);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
    end
    hit_any = |hit_vec;
  end

  always_comb begin
    found    = 1'b0;
    victim   = '0;
    best_age = '0;
    for (int w = 0; w < WAYS; w++) begin
      aged[w] = (vrow[w] && (age_row_q[w] != sacf_pkg::AGE_MAX)) ?
                age_row_q[w] + AW'(1) : age_row_q[w];
      if (!found) begin
        if (!vrow[w]) begin
          victim = WAY_W'(w);
          found  = 1'b1;
        end else if (aged[w] > best_age) begin
          best_age = aged[w];
          victim   = WAY_W'(w);
        end
      end
    end
    tag_row_new = tag_row_q;
    age_row_new = aged;
    tag_row_new[victim] = tag_c;
    age_row_new[victim] = '0;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sacf_pkg::ST_CLEAR: begin
        if (&clr_q) state_d = sacf_pkg::ST_IDLE;
      end
      sacf_pkg::ST_IDLE: begin
        if (cmd_valid_i) state_d = sacf_pkg::ST_LOOKUP;
      end
      sacf_pkg::ST_LOOKUP: begin
        if (cmd_q.kind == sacf_pkg::OP_READ) begin
          state_d = hit_any ? sacf_pkg::ST_READ : sacf_pkg::ST_FILL;
        end else begin
          state_d = sacf_pkg::ST_RESULT;
        end
      end
      sacf_pkg::ST_FILL: begin
        if (fill_idx_q == IDX_W'(LINE_WORDS)) state_d = sacf_pkg::ST_RESULT;
      end
      sacf_pkg::ST_READ: begin
        state_d = sacf_pkg::ST_RESULT;
      end
      sacf_pkg::ST_RESULT: begin
        if (!res_full_i) state_d = sacf_pkg::ST_IDLE;
      end
      default: state_d = sacf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    do_lookup = 1'b0;
    bm_we     = 1'b0;
    bm_waddr  = addr_c;
    bm_wdata  = cmd_q.wdata;
    bm_raddr  = base_c + ADDR_BITS'(fill_idx_q);
    dm_we     = 1'b0;
    dm_waddr  = d_index(hit_way, set_c, off_c);
    dm_wdata  = cmd_q.wdata;
    dm_raddr  = d_index(hit_way, set_c, off_c);
    row_we    = 1'b0;
    status_o.clearing  = 1'b0;
    status_o.res_valid = 1'b0;
    case (state_q)
      sacf_pkg::ST_CLEAR: begin
        status_o.clearing = 1'b1;
        bm_we    = 1'b1;
        bm_waddr = clr_q;
        bm_wdata = '0;
      end
      sacf_pkg::ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
      end
      sacf_pkg::ST_LOOKUP: begin
        do_lookup = 1'b1;
        if (cmd_q.kind == sacf_pkg::OP_READ) begin
          row_we = !hit_any;
        end else if (cmd_q.kind == sacf_pkg::OP_WRITE) begin
          bm_we = 1'b1;
          dm_we = hit_any;
        end
      end
      sacf_pkg::ST_FILL: begin
        dm_we    = (fill_idx_q != '0);
        dm_waddr = d_index(fill_way_q, set_c, fill_off);
        dm_wdata = bmem_rd_q;
      end
      sacf_pkg::ST_RESULT: begin
        status_o.res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bmem[bm_waddr] <= bm_wdata;
    end
    bmem_rd_q <= bmem[bm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dmem[dm_waddr] <= dm_wdata;
    end
    dmem_rd_q <= dmem[dm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      tag_mem[set_c] <= tag_row_new;
      age_mem[set_c] <= age_row_new;
    end
    if (cmd_pop_o) begin
      tag_row_q <= tag_mem[set_in];
      age_row_q <= age_mem[set_in];
      cmd_q     <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_lookup) begin
      hit_q      <= hit_any && (cmd_q.kind == sacf_pkg::OP_READ ||
                                cmd_q.kind == sacf_pkg::OP_WRITE);
      rdata_q    <= '0;
      fill_idx_q <= '0;
      fill_way_q <= victim;
    end
    if (state_q == sacf_pkg::ST_FILL) begin
      fill_idx_q <= fill_idx_q + IDX_W'(1);
      if (fill_idx_q != '0 && fill_off == off_c) begin
        rdata_q <= bmem_rd_q;
      end
    end
    if (state_q == sacf_pkg::ST_READ) begin
      rdata_q <= dmem_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sacf_pkg::ST_CLEAR;
      clr_q    <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      for (int s = 0; s < SETS; s++) begin
        valid_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == sacf_pkg::ST_CLEAR) begin
        clr_q <= clr_q + ADDR_BITS'(1);
      end
      if (do_lookup) begin
        if (cmd_q.kind == sacf_pkg::OP_FLUSH) begin
          hits_q   <= '0;
          misses_q <= '0;
          for (int s = 0; s < SETS; s++) begin
            valid_q[s] <= '0;
          end
        end else if (cmd_q.kind == sacf_pkg::OP_READ ||
                     cmd_q.kind == sacf_pkg::OP_WRITE) begin
          if (hit_any) begin
            if (~&hits_q) hits_q <= hits_q + CW'(1);
          end else begin
            if (~&misses_q) misses_q <= misses_q + CW'(1);
          end
        end
        if (row_we) begin
          valid_q[set_c][victim] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_o.read_data  = rdata_q;
    res_o.hit        = hit_q;
    res_o.hit_count  = hits_q;
    res_o.miss_count = misses_q;
  end

endmodule

### sv/set_assoc_cache_fifo_write_through_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_write_through_core
// Set-associative cache with FIFO replacement, write-through and no write
// allocate, in front of a byte-wide backing memory.
// ----------------------------------------------------------------------------
//  Channel  | Handshake        | Beat
//  access   | push / full      | req_i  (op, address, write_data)
//  result   | pop  / empty     | rsp_o  (read_data, hit, hit_count, miss_count)
//
//  In the back end a read hit passes LOOKUP, READ and RESULT; a write,
//  flush or unused op passes LOOKUP and RESULT; a read miss passes LOOKUP,
//  FILL and RESULT, copying the line one word per cycle through the single
//  read port of the backing memory. After reset the backing memory is cleared,
//  with full held high. Each side has a two-beat queue and can stall alone.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_write_through_core #(
  parameter int unsigned WAYS       = 8,
  parameter int unsigned SETS       = 32,
  parameter int unsigned LINE_WORDS = 32,
  parameter int unsigned ADDR_BITS  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  sacf_pkg::in_t  req_i,
  output logic           empty,
  input  logic           pop,
  output sacf_pkg::out_t rsp_o
);

  localparam int unsigned PTR_W  = $clog2(sacf_pkg::QDEPTH);
  localparam int unsigned CNT_QW = $clog2(sacf_pkg::QDEPTH + 1);

  logic              front_full, cmd_valid, cmd_pop, res_full;
  sacf_pkg::cmd_t    cmd;
  sacf_pkg::status_t status;
  sacf_pkg::out_t    res;
  sacf_pkg::out_t    oq_mem [sacf_pkg::QDEPTH];
  logic [PTR_W-1:0]  owr_q, ord_q;
  logic [CNT_QW-1:0] ocnt_q;
  logic              o_push, o_pop;

  sacf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push && !status.clearing),
    .req_i       (req_i),
    .full_o      (front_full),
    .cmd_pop_i   (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  sacf_back #(
    .WAYS       (WAYS),
    .SETS       (SETS),
    .LINE_WORDS (LINE_WORDS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .status_o    (status),
    .res_o       (res)
  );

  assign full     = front_full || status.clearing;
  assign res_full = (ocnt_q == CNT_QW'(sacf_pkg::QDEPTH));
  assign empty    = (ocnt_q == '0);
  assign rsp_o    = oq_mem[ord_q];
  assign o_push   = status.res_valid && !res_full;
  assign o_pop    = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (o_push) begin
      oq_mem[owr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (o_push) begin
        owr_q <= owr_q + PTR_W'(1);
      end
      if (o_pop) begin
        ord_q <= ord_q + PTR_W'(1);
      end
      if (o_push && !o_pop) begin
        ocnt_q <= ocnt_q + CNT_QW'(1);
      end else if (o_pop && !o_push) begin
        ocnt_q <= ocnt_q - CNT_QW'(1);
      end
    end
  end

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> full)
    else $error("input accepted during memory clearing");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= CNT_QW'(sacf_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_hit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.hit) |-> (rsp_o.hit_count != '0))
    else $error("hit reported with zero hit count");

  a_pop_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_pop && !o_push) |=> (ocnt_q == $past(ocnt_q) - CNT_QW'(1)))
    else $error("result queue did not drain on pop");

endmodule
